// File: hdl/multi_wave_phase_oscillator_unit_assert.svh
// Assertion macros for the multi-wave phase oscillator checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef MULTI_WAVE_PHASE_OSCILLATOR_UNIT_ASSERT_SVH
`define MULTI_WAVE_PHASE_OSCILLATOR_UNIT_ASSERT_SVH

// Checked only outside reset.
`define MWPO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define MWPO_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mwpo_pkg.sv
// Package for the multi-wave phase oscillator: sizes, codes, types,
// phase helpers and the quarter-wave sine table. No dependencies.
`default_nettype none

package mwpo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    // fixed field widths of the ports
    localparam int FUNC_W   = 2;
    localparam int OFFSET_W = 32;
    localparam int SAMPLE_W = 16;
    localparam int SHAPE_W  = 2;
    localparam int STEP_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QSIZE = 1 << TABLE_ADDR_BITS;

    // request functions
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ABSOLUTE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    // waveform codes
    localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_RESET = SHAPE_SINE;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd39370535;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd32768;

    typedef logic [PHASE_BITS-1:0]         phase_t;
    typedef logic [SHAPE_W-1:0]            shape_t;
    typedef logic signed [SAMPLE_BITS:0]   wave_t;   // range [-U, U]
    typedef logic [SAMPLE_BITS-1:0]        rom_word_t;
    typedef rom_word_t                     rom_t [0:QSIZE];

    // 32-bit field taken modulo one turn
    function automatic phase_t fit_phase(input logic [OFFSET_W-1:0] v);
        logic [PHASE_BITS+OFFSET_W-1:0] t;
        t = {{PHASE_BITS{1'b0}}, v};
        return t[PHASE_BITS-1:0];
    endfunction

    // phase cut (or zero-extended) to SAMPLE_BITS
    function automatic rom_word_t reduce_phase(input phase_t ph);
        logic [PHASE_BITS+SAMPLE_BITS-1:0] t;
        t = {ph, {SAMPLE_BITS{1'b0}}};
        return t[PHASE_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];
    endfunction

    // Q30 Taylor series to x^13, rounded half up, clamped to unity
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] e;
        localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
        localparam logic [63:0] HALF_PI = 64'd1686629713;
        localparam logic [63:0] UNITY   = 64'd1 << (SAMPLE_BITS - 1);
        for (int i = 0; i <= QSIZE; i++)
        begin
            x  = (HALF_PI * 64'(i)) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            d  = ((x2 * t) >> 30) / 156;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            d  = ((x2 * t) >> 30) / 110;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            d  = ((x2 * t) >> 30) / 72;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            d  = ((x2 * t) >> 30) / 42;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            d  = ((x2 * t) >> 30) / 20;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            d  = ((x2 * t) >> 30) / 6;
            t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            s  = (x * t) >> 30;
            e  = (s * UNITY + (ONE_Q30 >> 1)) >> 30;
            if (e > UNITY)
            begin
                e = UNITY;
            end
            r[i] = e[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

// File: hdl/mwpo_shaper.sv
// Waveform stage: saw, sine (quarter-wave table), square, triangle.
// Registered output. Uses mwpo_pkg.
`default_nettype none

module mwpo_shaper
    import mwpo_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  phase_t phase,
    input  shape_t shape,
    output wave_t  wave
);

    localparam wave_t UNITY_W = wave_t'(1) <<< (SAMPLE_BITS - 1);
    localparam logic signed [SAMPLE_BITS+1:0] UNITY_X = $signed({1'b0, UNITY_W});
    localparam phase_t HALF_TURN = phase_t'(1) << (PHASE_BITS - 1);
    localparam logic [TABLE_ADDR_BITS:0] ROM_TOP = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    rom_word_t                       ps;
    wave_t                           saw_w;
    wave_t                           abs_c;
    logic signed [SAMPLE_BITS+1:0]   tri_full;
    wave_t                           square_w;
    logic [1:0]                      quad;
    logic [TABLE_ADDR_BITS-1:0]      addr;
    logic [TABLE_ADDR_BITS:0]        idx;
    rom_word_t                       rom_val;
    wave_t                           sine_w;
    wave_t                           wave_next;
    wave_t                           wave_reg;

    always_comb
    begin
        ps       = reduce_phase(phase);
        saw_w    = $signed({1'b0, ps}) - UNITY_W;
        abs_c    = saw_w[SAMPLE_BITS] ? -saw_w : saw_w;
        // abs_c never exceeds unity, so its top bit is clear
        tri_full = $signed({abs_c, 1'b0}) - UNITY_X;

        if (phase == '0 || phase == HALF_TURN)
            square_w = '0;
        else if (phase[PHASE_BITS-1])
            square_w = -UNITY_W;
        else
            square_w = UNITY_W;

        quad    = phase[PHASE_BITS-1 -: 2];
        addr    = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        idx     = quad[0] ? ROM_TOP - {1'b0, addr} : {1'b0, addr};
        rom_val = SINE_ROM[idx];
        sine_w  = quad[1] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

        case (shape)
            SHAPE_SAW:      wave_next = saw_w;
            SHAPE_SINE:     wave_next = sine_w;
            SHAPE_SQUARE:   wave_next = square_w;
            SHAPE_TRIANGLE: wave_next = tri_full[SAMPLE_BITS:0];
            default:        wave_next = sine_w;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            wave_reg <= wave_next;
        end
    end

    assign wave = wave_reg;

endmodule

`default_nettype wire

// File: hdl/multi_wave_phase_oscillator_unit.sv
// Top level of the multi-wave phase oscillator (phase-accumulator DDS).
// Depends on mwpo_pkg and mwpo_shaper.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   s_*      | in  | s_tvalid / s_tready | tuser: func, tdata: phase_offset
//   m_*      | out | m_tvalid / m_tready | tdata: sample
//   cfg_*    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle unless output stalls fill the pipe; a sample passes
// the phase register, waveform register and output register in that order.
// The input stage holds the accumulator add.
// Clear and unused functions are accepted and give no sample.
// Reset puts the accumulator to zero and the registers to their reset values.
// Under a stall each stage holds its contents; s_tready stays high while any
// stage is free.
`default_nettype none

module multi_wave_phase_oscillator_unit
    import mwpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OFFSET_W-1:0]   s_tdata,    // [31:0] phase_offset
    input  logic [FUNC_W-1:0]     s_tuser,    // [1:0] func
    // sample out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // [15:0] sample
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = SAMPLE_BITS + 18;  // product of wave and gain
    localparam logic signed [PW-1:0] RND  = PW'(1) <<< (SAMPLE_BITS - 2);
    localparam logic signed [PW-1:0] SMAX = PW'(32767);
    localparam logic signed [PW-1:0] SMIN = PW'(-32768);

    // configuration
    shape_t              shape_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // accumulator
    phase_t              acc_reg;
    phase_t              acc_next;

    // pipeline occupancy
    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    logic                ready1;
    logic                ready2;
    logic                ready3;

    logic                s_fire;
    logic                cfg_fire;
    logic                gives_sample;
    phase_t              offset;
    phase_t              phase_next;
    phase_t              phase_reg;
    wave_t               wave;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] q;
    logic [SAMPLE_W-1:0]  sample_next;
    logic [SAMPLE_W-1:0]  sample_reg;

    // a stage takes new contents when empty or when it empties this cycle
    assign ready3 = !v3_reg || m_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign s_tready  = ready1;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign gives_sample = (s_tuser == FUNC_ADVANCE) || (s_tuser == FUNC_ABSOLUTE);
    assign offset       = fit_phase(s_tdata);
    assign phase_next   = (s_tuser == FUNC_ADVANCE) ? acc_reg + offset : offset;

    always_comb
    begin
        acc_next = acc_reg;
        if (s_fire)
        begin
            case (s_tuser)
                FUNC_ADVANCE: acc_next = acc_reg + fit_phase(step_reg);
                FUNC_CLEAR:   acc_next = '0;
                default:      acc_next = acc_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= SHAPE_RESET;
            step_reg  <= STEP_RESET;
            gain_reg  <= GAIN_RESET;
            acc_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_WAVE_SHAPE: shape_reg <= cfg_data[SHAPE_W-1:0];
                    REG_PHASE_STEP: step_reg  <= cfg_data[STEP_W-1:0];
                    REG_GAIN:       gain_reg  <= cfg_data[GAIN_W-1:0];
                    default:        ;
                endcase
            end
            acc_reg <= acc_next;
            if (ready1)
                v1_reg <= s_fire && gives_sample;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    // phase stage
    always_ff @(posedge clk)
    begin
        if (ready1 && s_fire)
        begin
            phase_reg <= phase_next;
        end
    end

    mwpo_shaper u_shaper (
        .clk   (clk),
        .load  (ready2 && v1_reg),
        .phase (phase_reg),
        .shape (shape_reg),
        .wave  (wave)
    );

    // scale by gain, round half up, saturate to the 16-bit sample
    always_comb
    begin
        prod    = PW'(wave) * PW'($signed({1'b0, gain_reg}));
        rnd_sum = prod + RND;
        q       = rnd_sum >>> (SAMPLE_BITS - 1);
        if (q > SMAX)
            sample_next = SMAX[SAMPLE_W-1:0];
        else if (q < SMIN)
            sample_next = SMIN[SAMPLE_W-1:0];
        else
            sample_next = q[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = sample_reg;

endmodule

`default_nettype wire

// File: hdl/mwpo_checker.sv
// Port-level checks for the multi-wave phase oscillator, bound to the top.
// Depends on mwpo_pkg and the assertion macro header.
`default_nettype none

`include "multi_wave_phase_oscillator_unit_assert.svh"

module mwpo_checker
    import mwpo_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [FUNC_W-1:0]   s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // a stalled sample holds
    `MWPO_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "sample dropped or changed under stall")

    // nothing offered once reset has been seen at an edge
    `MWPO_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "sample offered during reset")

    // empty output stage means the whole pipe can move
    `MWPO_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "request refused with output empty")

    // a sampling request is followed by a valid sample at the output
    `MWPO_ASSERT(a_latency, s_tvalid && s_tready && (s_tuser == FUNC_ADVANCE || s_tuser == FUNC_ABSOLUTE) |-> ##3 m_tvalid, "sample missing after request")

endmodule

bind multi_wave_phase_oscillator_unit mwpo_checker u_mwpo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for multi_wave_phase_oscillator_unit: directed table, then random phases.
// Needs mwpo_pkg and the RTL only; expected samples: typed in, else from an oscillator mirror.

module tb_top;
    import mwpo_pkg::*;

    // func and register codes that the package leaves without a name
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    localparam longint          UNITY      = 64'sd1 <<< (SAMPLE_BITS - 1);
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int SETTLE_CYCLES   = 8;     // three-stage pipe plus margin
    localparam int TAIL_CYCLES     = 10;
    localparam int QUIET_LIMIT     = 3000;  // longest legal quiet spell is the long receiver hold
    localparam int HOLD_CYCLES     = 400;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 150;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OFFSET_W-1:0]   s_tdata = '0;     // [31:0] phase_offset
    logic [FUNC_W-1:0]     s_tuser = '0;     // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // [15:0] sample
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    multi_wave_phase_oscillator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // ------------------------------------------------------------------
    // Oscillator mirror: registers, accumulator and quarter-wave table
    // ------------------------------------------------------------------
    shape_t                 shape_now;
    logic [STEP_W-1:0]      step_now;
    logic [GAIN_W-1:0]      gain_now;
    phase_t                 phase_now;
    logic [SAMPLE_BITS-1:0] sine_quarter [0:QSIZE];

    logic [SAMPLE_W-1:0]    pending_samples [$];   // samples still owed by the block
    int                     mismatches = 0;
    bit                     calm = 1'b0;           // no idling on either side
    bit                     hold_off_req = 1'b0;   // ask the receiver for one long stall

    // Q30 Taylor series of sin to x^13, nested form, rounded half up, clamped to unity
    function automatic void fill_sine_quarter();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned d;
        longint unsigned s;
        longint unsigned e;
        int unsigned     divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        for (int i = 0; i <= QSIZE; i++)
        begin
            x  = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            for (int k = 0; k < 6; k++)
            begin
                d = ((x2 * t) >> 30) / divs[k];
                t = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
            end
            s = (x * t) >> 30;
            e = (s * 64'(UNITY) + (ONE_Q30 >> 1)) >> 30;
            if (e > 64'(UNITY))
            begin
                e = 64'(UNITY);
            end
            sine_quarter[i] = e[SAMPLE_BITS-1:0];
        end
    endfunction

    // waveform at one phase, scaled by gain, rounded and saturated
    function automatic logic [SAMPLE_W-1:0] sample_at_phase(input phase_t ph);
        logic [SAMPLE_BITS-1:0] ps;
        int unsigned            addr;
        longint                 w;
        longint                 c;
        longint                 q;
        ps = ph[PHASE_BITS-1 -: SAMPLE_BITS];
        case (shape_now)
            SHAPE_SAW:
            begin
                w = longint'(ps) - UNITY;
            end
            SHAPE_SQUARE:
            begin
                // zero exactly at the start and at half a turn
                if (ph == '0 || ph == {1'b1, {(PHASE_BITS-1){1'b0}}})
                    w = 0;
                else
                    w = ph[PHASE_BITS-1] ? -UNITY : UNITY;
            end
            SHAPE_TRIANGLE:
            begin
                c = longint'(ps) - UNITY;
                w = 2 * ((c < 0) ? -c : c) - UNITY;
            end
            default:
            begin
                addr = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
                if (ph[PHASE_BITS-2])
                    addr = QSIZE - addr;   // odd quadrants run the table backwards
                w = longint'(sine_quarter[addr]);
                if (ph[PHASE_BITS-1])
                    w = -w;
            end
        endcase
        q = (w * longint'(gain_now) + (64'sd1 <<< (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // one accepted request; returns 1 when it owes a sample
    function automatic bit predict_sample(input logic [FUNC_W-1:0] f,
                                          input logic [OFFSET_W-1:0] off,
                                          output logic [SAMPLE_W-1:0] s);
        s = '0;
        case (f)
            FUNC_ADVANCE:
            begin
                s = sample_at_phase(phase_now + off);
                phase_now = phase_now + step_now;
                return 1'b1;
            end
            FUNC_ABSOLUTE:
            begin
                s = sample_at_phase(off);
                return 1'b1;
            end
            FUNC_CLEAR:
            begin
                phase_now = '0;
                return 1'b0;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    // extremes, reset value, small values and the rest for a register draw
    function automatic logic [31:0] draw_reg_value(input logic [31:0] top,
                                                   input logic [31:0] rst_val);
        case ($urandom_range(5))
            0: return 32'd0;
            1: return top;
            2: return rst_val;
            3: return 32'($urandom_range(1, 1000));
            default: return $urandom() & top;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [OFFSET_W-1:0] off,
                                input bit typed, input logic [SAMPLE_W-1:0] want);
        logic [SAMPLE_W-1:0] s;
        bit                  owes;
        while (!calm && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= off;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        owes = predict_sample(f, off, s);
        if (owes)
            pending_samples.push_back(typed ? want : s);
    endtask

    // register write once the pipe has emptied; clears leave no sample, hence the settle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WAVE_SHAPE: shape_now = val[SHAPE_W-1:0];
            REG_PHASE_STEP: step_now  = val[STEP_W-1:0];
            REG_GAIN:       gain_now  = val[GAIN_W-1:0];
            default:        ;   // unused index, nothing changes
        endcase
    endtask

    // receiver: random stalls, one long hold on request, none while calm
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample: expected none, actual %0d", $signed(m_tdata));
                mismatches++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_tdata !== want)
                begin
                    $error("sample: expected %0d, actual %0d", $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: request or register write per row. Expected samples
    // are typed in where obvious, otherwise taken from the mirror.
    // ------------------------------------------------------------------
    typedef enum logic { ROW_REQ, ROW_REG } row_kind_e;

    typedef struct packed {
        row_kind_e           kind;
        logic [1:0]          code;    // func or register index
        logic [31:0]         value;   // phase_offset or register data
        logic                typed;
        logic [SAMPLE_W-1:0] want;
    } script_row_t;

    localparam int SCRIPT_LEN = 35;
    localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // reset state: sine, unity gain, accumulator at zero
        '{ROW_REQ, FUNC_ADVANCE,   32'h0000_0000, 1'b1, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h4000_0000, 1'b0, 16'h0000},   // sine peak
        '{ROW_REQ, FUNC_ABSOLUTE,  32'hC000_0000, 1'b0, 16'h0000},   // sine trough
        '{ROW_REQ, FUNC_CLEAR,     32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h0000_0000, 1'b1, 16'h0000},   // just cleared
        '{ROW_REQ, FUNC_UNUSED,    32'hFFFF_FFFF, 1'b0, 16'h0000},   // ignored
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h8000_0000, 1'b1, 16'h0000},
        // saw ends
        '{ROW_REG, REG_WAVE_SHAPE, 32'(SHAPE_SAW), 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h0000_0000, 1'b1, 16'h8000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'hFFFF_FFFF, 1'b1, 16'h7FFF},
        '{ROW_REQ, FUNC_ADVANCE,   32'hFFFF_FFFF, 1'b0, 16'h0000},   // offset sum wraps
        // square with gain above unity: zero points and saturation
        '{ROW_REG, REG_WAVE_SHAPE, 32'(SHAPE_SQUARE), 1'b0, 16'h0000},
        '{ROW_REG, REG_GAIN,       32'h0000_FFFF, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h0000_0000, 1'b1, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h8000_0000, 1'b1, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h0000_0001, 1'b1, 16'h7FFF},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'hFFFF_FFFF, 1'b1, 16'h8000},
        // triangle, gain zero then unity, largest step
        '{ROW_REG, REG_WAVE_SHAPE, 32'(SHAPE_TRIANGLE), 1'b0, 16'h0000},
        '{ROW_REG, REG_GAIN,       32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h0000_0000, 1'b1, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h1234_5678, 1'b1, 16'h0000},
        '{ROW_REG, REG_GAIN,       32'h0000_8000, 1'b0, 16'h0000},
        '{ROW_REG, REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h0000_0000, 1'b1, 16'h7FFF},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h8000_0000, 1'b1, 16'h8000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h8000_0000, 1'b0, 16'h0000},
        // sine, zero step, smallest nonzero gain, write to the unused index
        '{ROW_REG, REG_PHASE_STEP, 32'h0000_0000, 1'b0, 16'h0000},
        '{ROW_REG, REG_WAVE_SHAPE, 32'(SHAPE_SINE), 1'b0, 16'h0000},
        '{ROW_REG, REG_GAIN,       32'h0000_0001, 1'b0, 16'h0000},
        '{ROW_REG, REG_UNUSED,     32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'hAAAA_AAAA, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ADVANCE,   32'h5555_5555, 1'b0, 16'h0000},
        '{ROW_REQ, FUNC_ABSOLUTE,  32'h7FFF_FFFF, 1'b0, 16'h0000}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [FUNC_W-1:0]   f;
        logic [OFFSET_W-1:0] off;
        int                  r;
        shape_now = SHAPE_RESET;
        step_now  = STEP_RESET;
        gain_now  = GAIN_RESET;
        phase_now = '0;
        fill_sine_quarter();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].kind == ROW_REG)
                write_reg(SCRIPT[i].code, SCRIPT[i].value);
            else
                send_request(SCRIPT[i].code, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // random phases, fresh register settings before each; the shape
        // code rotates so every waveform gets two phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_WAVE_SHAPE, ($urandom() & ~32'h3) | 32'(p % 4));
            write_reg(REG_PHASE_STEP, draw_reg_value(32'hFFFF_FFFF, 32'(STEP_RESET)));
            write_reg(REG_GAIN, draw_reg_value(32'h0000_FFFF, 32'(GAIN_RESET))
                                | ($urandom() & 32'hFFFF_0000));
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, $urandom());

            calm = (p == 2);
            if (p == 5)
                hold_off_req = 1'b1;   // receiver stalls long, input backs up

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    f = FUNC_ADVANCE;
                else if (r < 85)
                    f = FUNC_ABSOLUTE;
                else if (r < 93)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_UNUSED;
                // plain ticks and modulation take most draws; the rest is corners
                case ($urandom_range(9))
                    0, 1, 2, 3: off = '0;
                    4, 5, 6, 7: off = $urandom();
                    8:          off = {$urandom_range(3) == 0, 31'(0)} - 32'($urandom_range(1));
                    default:    off = (32'($urandom_range(3)) << 30) ^ 32'($urandom_range(7));
                endcase
                send_request(f, off, 1'b0, '0);
            end
            calm = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mwpo_pkg.sv
hdl/mwpo_shaper.sv
hdl/multi_wave_phase_oscillator_unit.sv
hdl/mwpo_checker.sv
bench/tb_top.sv
